[hdl/fss_pkg.sv]
// Package of the fuzzy subsequence scorer: widths, character codes, register
// indexes, the item and state types and the scoring helper functions.
// Depends on nothing.
`default_nettype none

package fss_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_BYTES   = 32;
    localparam int PAT_SEL_W   = $clog2(PAT_BYTES);
    localparam int IDX_W       = 6;
    localparam int SCORE_W     = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int BYTES_PER_REG = CFG_DATA_W / 8;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
    localparam logic [IDX_W-1:0]   LEN_MAX   = {IDX_W{1'b1}};

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LEN = 3'd0,
        CFG_PAT_A   = 3'd1,
        CFG_PAT_B   = 3'd2,
        CFG_PAT_C   = 3'd3,
        CFG_PAT_D   = 3'd4
    } t_cfg_idx;

    typedef logic [SCORE_W-1:0] t_score;
    typedef logic [PAT_BYTES-1:0][7:0] t_pattern;

    typedef struct packed {
        logic [7:0] text_char;
        logic       char_valid;
        logic       last;
        logic       list_mode;
        logic [1:0] weight;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0] pattern_index;
        logic [IDX_W-1:0] run_length;
        t_score           word_score;
        t_score           best_score;
        logic [7:0]       previous_char;
        logic [IDX_W-1:0] word_length;
        logic             at_word_start;
    } t_state;

    localparam t_state STATE_RST = '{
        pattern_index: '0,
        run_length:    '0,
        word_score:    '0,
        best_score:    '0,
        previous_char: '0,
        word_length:   '0,
        at_word_start: 1'b1
    };

    function automatic logic is_up(logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_lo(logic [7:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic logic [7:0] to_lo(logic [7:0] c);
        return is_up(c) ? c + CASE_OFS : c;
    endfunction

    function automatic t_score sat_score(logic [SCORE_W:0] s);
        return (s > {1'b0, SCORE_MAX}) ? SCORE_MAX : s[SCORE_W-1:0];
    endfunction

    // Score of the current word as it stands.
    function automatic t_score word_result(logic [IDX_W-1:0] plen, t_state st);
        logic [IDX_W:0] lim;
        lim = {1'b0, plen} + (IDX_W+1)'(2);
        if (plen == '0) begin
            return t_score'(1);
        end else if (st.word_length == '0) begin
            return '0;
        end else if (st.pattern_index < plen) begin
            return '0;
        end else if ({1'b0, st.word_length} <= lim) begin
            return sat_score({1'b0, st.word_score} + (SCORE_W+1)'(15));
        end else begin
            return st.word_score;
        end
    endfunction

endpackage

`default_nettype wire

[hdl/fss_if.sv]
// Handshake channels of the fuzzy subsequence scorer: text items in, scores out.
// Each carries valid, ready and its payload. Depends on nothing.
`default_nettype none

interface fss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       char_valid;
    logic       last;
    logic       list_mode;
    logic [1:0] weight;

    modport source (output valid, text_char, char_valid, last, list_mode, weight,
                    input ready);
    modport sink   (input valid, text_char, char_valid, last, list_mode, weight,
                    output ready);
endinterface

interface fss_out_if;
    logic        valid;
    logic        ready;
    logic [12:0] score;

    modport source (output valid, score, input ready);
    modport sink   (input valid, score, output ready);
endinterface

`default_nettype wire

[hdl/fss_core.sv]
// Per-character update of the fuzzy subsequence scorer: from the current text
// state and one item it forms the next state and, on a final item, the score.
// Depends on fss_pkg.
`default_nettype none

module fss_core import fss_pkg::*; (
    input  wire t_state           i_state,
    input  wire t_item            i_item,
    input  wire t_pattern         i_pattern,
    input  wire [IDX_W-1:0]       i_plen,
    output t_state                o_state_nxt,
    output t_score                o_score
);

    logic                 sep;
    logic                 take;
    logic [7:0]           lc;
    logic [7:0]           cur;
    logic                 up_cur;
    logic                 active;
    logic                 match;
    logic                 boundary;
    logic [8:0]           pts;
    t_score               res_cur;
    t_score               res_after;
    t_score               fin;
    logic [SCORE_W+1:0]   prod;
    t_state               after;

    always_comb begin
        sep    = i_item.char_valid && i_item.list_mode && (i_item.text_char == CH_SEMI);
        take   = i_item.char_valid && !sep;
        lc     = to_lo(i_item.text_char);
        cur    = i_item.list_mode ? lc : i_item.text_char;
        up_cur = is_up(cur);
        active = i_state.pattern_index < i_plen;
        match  = active && (lc == i_pattern[i_state.pattern_index[PAT_SEL_W-1:0]]);

        boundary = i_state.at_word_start ||
                   (i_state.previous_char == CH_SPACE) ||
                   (i_state.previous_char == CH_DASH) ||
                   (i_state.previous_char == CH_USCORE) ||
                   (i_state.previous_char == CH_DOT) ||
                   (is_lo(i_state.previous_char) && up_cur);
        pts = 9'd1
            + (boundary ? 9'd10 : 9'd0)
            + {1'b0, i_state.run_length, 2'b00}
            + (i_state.at_word_start ? 9'd8 : 9'd0)
            + (up_cur ? 9'd1 : 9'd0);

        res_cur = word_result(i_plen, i_state);

        after = i_state;
        if (sep) begin
            if ((i_state.word_length != '0) && (res_cur > i_state.best_score)) begin
                after.best_score = res_cur;
            end
            after.pattern_index = STATE_RST.pattern_index;
            after.run_length    = STATE_RST.run_length;
            after.word_score    = STATE_RST.word_score;
            after.previous_char = STATE_RST.previous_char;
            after.word_length   = STATE_RST.word_length;
            after.at_word_start = STATE_RST.at_word_start;
        end else if (take) begin
            if (match) begin
                after.word_score    = sat_score({1'b0, i_state.word_score}
                                                + (SCORE_W+1)'(pts));
                after.run_length    = i_state.run_length + IDX_W'(1);
                after.pattern_index = i_state.pattern_index + IDX_W'(1);
            end else if (active) begin
                after.run_length = '0;
            end
            after.previous_char = cur;
            if (i_state.word_length < LEN_MAX) begin
                after.word_length = i_state.word_length + IDX_W'(1);
            end
            after.at_word_start = 1'b0;
        end

        res_after = word_result(i_plen, after);
        if (i_item.list_mode) begin
            fin = after.best_score;
            if ((after.word_length != '0) && (res_after > fin)) begin
                fin = res_after;
            end
        end else begin
            fin = res_after;
        end
        prod    = (SCORE_W+2)'(fin) * (SCORE_W+2)'(i_item.weight);
        o_score = (prod > (SCORE_W+2)'(SCORE_MAX)) ? SCORE_MAX : prod[SCORE_W-1:0];

        o_state_nxt = i_item.last ? STATE_RST : after;
    end

endmodule

`default_nettype wire

[hdl/fuzzy_subsequence_scorer.sv]
// Top level of the fuzzy subsequence scorer: configuration registers, input
// register, text state and result register. Depends on fss_pkg, fss_if and fss_core.
//
// Usage: write pattern_length (index 0) and the four pattern byte registers
// (indexes 1 to 4) through i_cfg_we, i_cfg_idx and i_cfg_data while the block
// is idle. Then stream the characters of one text on i_item, one transaction
// per character, with last set on the final item. An item with char_valid low
// carries no character; only its last, list_mode and weight fields count. Every
// final item yields one transaction on o_result carrying the weighted score;
// other items yield none.
// An accepted item is held in the input register; when it is applied, the text
// state is updated and, for a final item, the score is loaded into the result
// register, from which it is offered on o_result.
// Throughput: one item per cycle, set by the state update, but for the stall below.
// Reset (synchronous, active low) clears the pattern registers, the text state
// and both valid flags. When the receiver stalls with a score pending, items
// without last still advance; a final item waits in the input register and
// i_item.ready drops until the score is taken.
`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    fss_in_if.sink                i_item,
    fss_out_if.source             o_result
);

    logic [IDX_W-1:0] r_pat_len;
    t_pattern         r_pattern;
    logic [IDX_W-1:0] plen;

    logic   r_s1_valid;
    t_item  r_s1_item;
    t_state r_state;
    t_state n_state;
    t_score n_score;
    logic   r_out_valid;
    t_score r_out_score;

    logic   out_free;
    logic   s1_fire;
    logic   in_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
            r_pattern <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PAT_LEN: r_pat_len <= i_cfg_data[IDX_W-1:0];
                CFG_PAT_A:   r_pattern[0*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_data;
                CFG_PAT_B:   r_pattern[1*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_data;
                CFG_PAT_C:   r_pattern[2*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_data;
                CFG_PAT_D:   r_pattern[3*BYTES_PER_REG +: BYTES_PER_REG] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign plen = (r_pat_len > IDX_W'(MAX_PATTERN)) ? IDX_W'(MAX_PATTERN) : r_pat_len;

    assign out_free     = !r_out_valid || o_result.ready;
    assign s1_fire      = r_s1_valid && (out_free || !r_s1_item.last);
    assign i_item.ready = !r_s1_valid || s1_fire;
    assign in_fire      = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= '{
                text_char:  i_item.text_char,
                char_valid: i_item.char_valid,
                last:       i_item.last,
                list_mode:  i_item.list_mode,
                weight:     i_item.weight
            };
        end
    end

    fss_core u_core (
        .i_state     (r_state),
        .i_item      (r_s1_item),
        .i_pattern   (r_pattern),
        .i_plen      (plen),
        .o_state_nxt (n_state),
        .o_score     (n_score)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (s1_fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_item.last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_item.last) begin
            r_out_score <= n_score;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.score = r_out_score;

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_item.last |=> r_out_valid)
        else $error("A final item did not load the result register.");

    a_last_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_fire && r_s1_item.last |=> (r_state.pattern_index == '0) &&
            (r_state.word_length == '0) && (r_state.best_score == '0) &&
            r_state.at_word_start)
        else $error("Text state was not cleared after a final item.");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pattern_index <= IDX_W'(MAX_PATTERN))
        else $error("Pattern index ran past the pattern.");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.run_length <= r_state.pattern_index)
        else $error("Run length exceeds the matched count.");

endmodule

`default_nettype wire

[tb/fuzzy_subsequence_scorer_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the fuzzy subsequence scorer: directed and random texts are
// streamed on the item channel and every score transaction is checked against a built-in
// scoring model. Depends on fss_pkg, fss_if and fuzzy_subsequence_scorer.

module fuzzy_subsequence_scorer_test;
    import fss_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 160;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fss_in_if  item_bus();
    fss_out_if res_bus();

    fuzzy_subsequence_scorer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_bus),
        .o_result   (res_bus)
    );

    t_item      text_items[$];
    t_score     expected_scores[$];
    logic [7:0] text_buf[$];
    int         queued_items;
    int         quiet_cycles;
    t_idle_mode idle_mode;
    bit         in_fire;
    bit         failed;
    bit         hold_go;
    bit         hold_off;

    logic [5:0] cfg_len;
    logic [7:0] cfg_chr  [PAT_BYTES];
    logic [7:0] pat_next [PAT_BYTES];

    logic [5:0] match_pos;
    logic [5:0] run_len;
    logic [5:0] word_len;
    t_score     word_pts;
    t_score     best_pts;
    logic [7:0] prev_chr;
    logic       word_start;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_upper_ch(logic [7:0] c);
        return (c >= CH_UP_A) && (c <= CH_UP_Z);
    endfunction

    function automatic logic is_lower_ch(logic [7:0] c);
        return (c >= CH_LO_A) && (c <= CH_LO_Z);
    endfunction

    function automatic t_score clip(int unsigned v);
        return (v > SCORE_MAX) ? SCORE_MAX : t_score'(v);
    endfunction

    function automatic logic [5:0] active_len();
        return (cfg_len > MAX_PATTERN) ? 6'(MAX_PATTERN) : cfg_len;
    endfunction

    function automatic t_score word_value();
        logic [5:0] n;
        n = active_len();
        if (n == 0) return t_score'(1);
        if (word_len == 0) return '0;
        if (match_pos < n) return '0;
        if (word_len <= n + 2) return clip(word_pts + 15);
        return word_pts;
    endfunction

    task automatic restart_word();
        match_pos  = '0;
        run_len    = '0;
        word_pts   = '0;
        prev_chr   = '0;
        word_len   = '0;
        word_start = 1'b1;
    endtask

    task automatic take_char(logic [7:0] c, logic list);
        logic [7:0]  lc;
        logic [7:0]  cur;
        int unsigned pts;
        lc  = is_upper_ch(c) ? c + CASE_OFS : c;
        cur = list ? lc : c;
        if (match_pos < active_len()) begin
            if (lc == cfg_chr[match_pos]) begin
                pts = 1;
                if (word_start || prev_chr == CH_SPACE || prev_chr == CH_DASH ||
                    prev_chr == CH_USCORE || prev_chr == CH_DOT ||
                    (is_lower_ch(prev_chr) && is_upper_ch(cur))) pts += 10;
                pts += 4 * run_len;
                if (word_start) pts += 8;
                if (is_upper_ch(cur)) pts += 1;
                word_pts  = clip(word_pts + pts);
                run_len   = run_len + 1;
                match_pos = match_pos + 1;
            end else begin
                run_len = '0;
            end
        end
        prev_chr = cur;
        if (word_len != LEN_MAX) word_len = word_len + 1;
        word_start = 1'b0;
    endtask

    task automatic score_item(input t_item it, output logic done, output t_score result);
        t_score      s;
        t_score      w;
        int unsigned r;
        done   = 1'b0;
        result = '0;
        if (it.char_valid) begin
            if (it.list_mode && it.text_char == CH_SEMI) begin
                if (word_len != 0) begin
                    w = word_value();
                    if (w > best_pts) best_pts = w;
                end
                restart_word();
            end else begin
                take_char(it.text_char, it.list_mode);
            end
        end
        if (it.last) begin
            if (it.list_mode) begin
                s = best_pts;
                if (word_len != 0) begin
                    w = word_value();
                    if (w > s) s = w;
                end
            end else begin
                s = word_value();
            end
            r      = s * it.weight;
            result = clip(r);
            done   = 1'b1;
            restart_word();
            best_pts = '0;
        end
    endtask

    function automatic bit sender_rests();
        case (idle_mode)
            IDLE_SEND: return $urandom_range(99) < 47;
            IDLE_BOTH: return $urandom_range(99) < 19;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_rests();
        case (idle_mode)
            IDLE_RECV: return $urandom_range(99) < 47;
            IDLE_BOTH: return $urandom_range(99) < 19;
            default:   return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin : drive_items
        t_item nxt;
        if (!i_rst_n) begin
            item_bus.valid <= 1'b0;
        end else if (!item_bus.valid || in_fire) begin
            if (text_items.size() != 0 && !sender_rests()) begin
                nxt = text_items.pop_front();
                item_bus.valid      <= 1'b1;
                item_bus.text_char  <= nxt.text_char;
                item_bus.char_valid <= nxt.char_valid;
                item_bus.last       <= nxt.last;
                item_bus.list_mode  <= nxt.list_mode;
                item_bus.weight     <= nxt.weight;
            end else begin
                item_bus.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= !hold_off && !receiver_rests();
        end
    end

    // The receiver holds off long enough for a final item to back up into the input.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin : check_scores
        logic   done;
        t_score predicted;
        t_item  seen;
        in_fire = 1'b0;
        if (i_rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                if (expected_scores.size() == 0) begin
                    $error("score: expected no transaction, actual %0d", res_bus.score);
                    failed = 1'b1;
                end else begin
                    predicted = expected_scores.pop_front();
                    if (res_bus.score !== predicted) begin
                        $error("score: expected %0d, actual %0d", predicted, res_bus.score);
                        failed = 1'b1;
                    end
                end
            end
            if (item_bus.valid && item_bus.ready) begin
                in_fire         = 1'b1;
                seen.text_char  = item_bus.text_char;
                seen.char_valid = item_bus.char_valid;
                seen.last       = item_bus.last;
                seen.list_mode  = item_bus.list_mode;
                seen.weight     = item_bus.weight;
                score_item(seen, done, predicted);
                if (done) expected_scores.insert(expected_scores.size(), predicted);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic put(logic [7:0] c, logic valid, logic last, logic list, logic [1:0] wt);
        t_item it;
        it.text_char  = c;
        it.char_valid = valid;
        it.last       = last;
        it.list_mode  = list;
        it.weight     = wt;
        text_items.insert(text_items.size(), it);
        queued_items++;
    endtask

    task automatic put_str(string s, logic list, logic [1:0] wt);
        for (int i = 0; i < s.len(); i++) put(s[i], 1'b1, i == s.len() - 1, list, wt);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pattern_word(int r);
        logic [CFG_DATA_W-1:0] w;
        for (int b = 0; b < BYTES_PER_REG; b++) w[b*8 +: 8] = pat_next[r*BYTES_PER_REG + b];
        return w;
    endfunction

    task automatic load_pattern(logic [5:0] len);
        put_reg(CFG_PAT_LEN, CFG_DATA_W'(len));
        put_reg(CFG_PAT_A, pattern_word(0));
        put_reg(CFG_PAT_B, pattern_word(1));
        put_reg(CFG_PAT_C, pattern_word(2));
        put_reg(CFG_PAT_D, pattern_word(3));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_len = len;
        for (int i = 0; i < PAT_BYTES; i++) cfg_chr[i] = pat_next[i];
    endtask

    task automatic set_pattern(string s);
        for (int i = 0; i < PAT_BYTES; i++) pat_next[i] = (i < s.len()) ? s[i] : 8'h00;
    endtask

    function automatic logic [5:0] phase_len(int p);
        case (p)
            0:       return 6'd1;
            1:       return 6'd32;
            2:       return 6'd3;
            3:       return 6'd63;
            4:       return 6'd5;
            5:       return 6'd2;
            6:       return 6'd40;
            7:       return 6'd8;
            8:       return 6'd4;
            9:       return 6'd20;
            10:      return 6'd6;
            default: return 6'd0;
        endcase
    endfunction

    task automatic pick_pattern(int p);
        string alphabet;
        int    n;
        alphabet = "abcdefghijklmnopqrstuvwxyz0-_. ";
        for (int i = 0; i < PAT_BYTES; i++) pat_next[i] = 8'($urandom_range(0, 255));
        n = (phase_len(p) > MAX_PATTERN) ? MAX_PATTERN : phase_len(p);
        for (int i = 0; i < n; i++) begin
            pat_next[i] = (p == 6) ? CH_DASH : alphabet[$urandom_range(0, alphabet.len() - 1)];
        end
        // An uppercase pattern byte can never be matched.
        if (p == 8) pat_next[$urandom_range(0, n - 1)] = 8'(CH_UP_A + $urandom_range(0, 25));
    endtask

    function automatic logic [7:0] filler();
        case ($urandom_range(0, 5))
            0: return 8'(CH_LO_A + $urandom_range(0, 25));
            1: return 8'(CH_UP_A + $urandom_range(0, 25));
            2: begin
                case ($urandom_range(0, 3))
                    0:       return CH_SPACE;
                    1:       return CH_DASH;
                    2:       return CH_USCORE;
                    default: return CH_DOT;
                endcase
            end
            3: begin
                if (active_len() != 0) return cfg_chr[$urandom_range(0, active_len() - 1)];
                return 8'($urandom_range(0, 255));
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_word();
        int         n;
        int         style;
        int         skip_at;
        logic [7:0] c;
        n     = active_len();
        style = $urandom_range(0, 39);
        if (style == 0) begin
            repeat ($urandom_range(64, 70)) text_buf.insert(text_buf.size(), filler());
        end else if (n != 0 && style < 28) begin
            skip_at = -1;
            if ($urandom_range(0, 4) == 0) skip_at = $urandom_range(0, n - 1);
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), filler());
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 2)) text_buf.insert(text_buf.size(), filler());
                end
                c = cfg_chr[i];
                if (is_lower_ch(c) && $urandom_range(0, 2) == 0) c = c - CASE_OFS;
                if (i != skip_at) text_buf.insert(text_buf.size(), c);
            end
            if ($urandom_range(0, 2) == 0) begin
                repeat ($urandom_range(1, 3)) text_buf.insert(text_buf.size(), filler());
            end
        end else begin
            repeat ($urandom_range(0, 6)) text_buf.insert(text_buf.size(), filler());
        end
    endtask

    task automatic queue_text(logic list);
        logic tail_empty;
        logic mode;
        tail_empty = (text_buf.size() == 0) || ($urandom_range(0, 9) == 0);
        for (int k = 0; k < text_buf.size(); k++) begin
            if ($urandom_range(0, 19) == 0) begin
                put(8'($urandom_range(0, 255)), 1'b0, 1'b0, list, 2'($urandom_range(1, 3)));
            end
            mode = ($urandom_range(0, 24) == 0) ? !list : list;
            put(text_buf[k], 1'b1, (k == text_buf.size() - 1) && !tail_empty, mode,
                2'($urandom_range(1, 3)));
        end
        if (tail_empty) put(8'($urandom_range(0, 255)), 1'b0, 1'b1, list, 2'($urandom_range(1, 3)));
    endtask

    task automatic gen_text(logic list);
        int words;
        text_buf.delete();
        if (!list) begin
            add_word();
        end else begin
            words = $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), CH_SEMI);
            for (int w = 0; w < words; w++) begin
                if (w > 0) begin
                    text_buf.insert(text_buf.size(), CH_SEMI);
                    if ($urandom_range(0, 4) == 0) text_buf.insert(text_buf.size(), CH_SEMI);
                end
                add_word();
            end
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), CH_SEMI);
        end
        queue_text(list);
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (text_items.size() != 0 || item_bus.valid || expected_scores.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_PAT_LEN;
        i_cfg_data          = '0;
        item_bus.valid      = 1'b0;
        item_bus.text_char  = '0;
        item_bus.char_valid = 1'b0;
        item_bus.last       = 1'b0;
        item_bus.list_mode  = 1'b0;
        item_bus.weight     = '0;
        res_bus.ready       = 1'b0;
        idle_mode           = IDLE_NONE;
        cfg_len             = '0;
        for (int i = 0; i < PAT_BYTES; i++) cfg_chr[i] = '0;
        restart_word();
        best_pts = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Start of text, case change and separator boundaries, empty text, list words,
        // an item without a character and a zero weight.
        set_pattern("ab");
        load_pattern(6'd2);
        put_str("Ab", 1'b0, 2'd3);
        put_str("xaB", 1'b0, 2'd2);
        put_str("-a.b", 1'b0, 2'd1);
        put(8'hFF, 1'b0, 1'b1, 1'b0, 2'd2);
        put_str(";ab;;b", 1'b1, 2'd1);
        put(CH_SEMI, 1'b0, 1'b0, 1'b1, 2'd1);
        put_str("ab", 1'b0, 2'd0);
        drain();

        // Empty pattern: plain text, list words, a list with no word and an empty text.
        set_pattern("");
        load_pattern(6'd0);
        put(8'h80, 1'b1, 1'b1, 1'b0, 2'd3);
        put_str(";;q", 1'b1, 2'd2);
        put_str(";;", 1'b1, 2'd1);
        put(8'h00, 1'b0, 1'b1, 1'b0, 2'd3);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            idle_mode = t_idle_mode'(p % 4);
            pick_pattern(p);
            load_pattern(phase_len(p));
            if (p == 4) hold_go = 1'b1;
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) gen_text($urandom_range(0, 9) < 3);
            drain();
        end

        if (!failed) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule
